// File: rtl/core/fdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_pkg
// shared types, codes and defaults for the free-run direction picker
// ----------------------------------------------------------------------------
package fdp_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    localparam int COORD_W = 6;
    localparam int LIM_W   = 7;
    localparam int RUN_W   = 7;
    localparam int DIR_W   = 3;
    localparam int POS_W   = 9;   // signed walk position, -1 .. 127
    localparam int CFG_IDX_W = 2;

    localparam logic [LIM_W-1:0] LIM_RESET = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd3;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd4;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               blocked_bit;
        logic               seen_bit;
        logic [DIR_W-1:0]   skip_dir;
    } t_in_item;

    typedef struct packed {
        logic [DIR_W-1:0] best_dir;
        logic [RUN_W-1:0] best_run;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_WALK,
        S_EMIT
    } t_fdp_state;

    // controller to datapath
    typedef struct packed {
        logic wr_cell;
        logic load_query;
        logic step;
        logic finish;
        logic fin_plus;
        logic emit;
    } t_fdp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic cell_open;
        logic next_in;
        logic last_dir;
        logic out_free;
    } t_fdp_stat;

endpackage

// File: rtl/core/fdp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_ctrl
// sequencer: takes items, walks the four rays one step a cycle, emits result
// ----------------------------------------------------------------------------
module fdp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fdp_pkg::t_fdp_stat i_stat,
    output fdp_pkg::t_fdp_cmd  o_cmd
);
    import fdp_pkg::*;

    t_fdp_state r_state;
    t_fdp_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_stat.is_query) begin
                        o_cmd.load_query = 1'b1;
                        n_state          = S_FIRST;
                    end else begin
                        o_cmd.wr_cell = 1'b1;
                    end
                end
            end
            S_FIRST: begin
                // the start cell is never tested, only the bounds of the first step
                if (i_stat.next_in) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_WALK;
                end else begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.fin_plus = 1'b1;
                    n_state        = i_stat.last_dir ? S_EMIT : S_FIRST;
                end
            end
            S_WALK: begin
                if (!i_stat.cell_open) begin
                    o_cmd.finish = 1'b1;
                    n_state      = i_stat.last_dir ? S_EMIT : S_FIRST;
                end else if (i_stat.next_in) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.fin_plus = 1'b1;
                    n_state        = i_stat.last_dir ? S_EMIT : S_FIRST;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_step_finish_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.step && o_cmd.finish))
        else $error("step and finish in the same cycle");

    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("emit not followed by idle");

    a_query_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_query |=> (r_state == S_FIRST))
        else $error("query did not start a walk");

    a_walk_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> (r_state == S_WALK))
        else $error("step not followed by walk state");
`endif

endmodule

// File: rtl/core/fdp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_datapath
// cell maps, config registers, walk position and counter, best tracking
// ----------------------------------------------------------------------------
module fdp_datapath #(
    parameter int MAX_COLS = fdp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = fdp_pkg::MAX_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fdp_pkg::t_in_item                   i_in_item,
    input  logic                                i_cfg_valid,
    input  logic [fdp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fdp_pkg::LIM_W-1:0]           i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output fdp_pkg::t_out_item                  o_out_item,
    input  fdp_pkg::t_fdp_cmd                   i_cmd,
    output fdp_pkg::t_fdp_stat                  o_stat
);
    import fdp_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    // two bits a cell: {blocked, seen}
    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rd;

    logic [LIM_W-1:0] r_rows;
    logic [LIM_W-1:0] r_cols;
    logic [LIM_W-1:0] nrows;
    logic [LIM_W-1:0] ncols;

    logic [COORD_W-1:0]     r_start_x;
    logic [COORD_W-1:0]     r_start_y;
    logic [DIR_W-1:0]       r_skip;
    logic [DIR_W-1:0]       r_dir;
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;
    logic signed [POS_W-1:0] nx;
    logic signed [POS_W-1:0] ny;
    logic [RUN_W-1:0]       r_cnt;
    logic [RUN_W-1:0]       fin_cnt;
    logic [RUN_W-1:0]       r_best_run;
    logic [DIR_W-1:0]       r_best_dir;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic              wr_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // configuration, limits saturated to storage size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= LIM_RESET;
            r_cols <= LIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS_IN_USE: r_rows <= i_cfg_data;
                CFG_COLS_IN_USE: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign nrows = (32'(r_rows) > MAX_ROWS) ? LIM_W'(MAX_ROWS) : r_rows;
    assign ncols = (32'(r_cols) > MAX_COLS) ? LIM_W'(MAX_COLS) : r_cols;

    // cell writes
    assign wr_ok   = (32'(i_in_item.cell_x) < MAX_COLS) && (32'(i_in_item.cell_y) < MAX_ROWS);
    assign wr_addr = ADDR_W'(32'(i_in_item.cell_y) * MAX_COLS + 32'(i_in_item.cell_x));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_cell && wr_ok) begin
            r_mem[wr_addr] <= {i_in_item.blocked_bit, i_in_item.seen_bit};
        end
    end

    // next position along the current ray
    always_comb begin
        nx = r_x;
        ny = r_y;
        case (r_dir)
            DIR_EAST:  nx = r_x + POS_W'(1);
            DIR_WEST:  nx = r_x - POS_W'(1);
            DIR_NORTH: ny = r_y + POS_W'(1);
            default:   ny = r_y - POS_W'(1);
        endcase
    end

    assign o_stat.next_in = (nx >= 0) && (nx < $signed({2'b00, ncols}))
                         && (ny >= 0) && (ny < $signed({2'b00, nrows}));

    // in bounds the position fits eight bits
    assign rd_addr = ADDR_W'(32'(ny[7:0]) * MAX_COLS + 32'(nx[7:0]));

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
    end

    assign o_stat.cell_open = ~r_rd[1] & ~r_rd[0];
    assign o_stat.is_query  = (i_in_item.op == OP_QUERY);
    assign o_stat.last_dir  = (r_dir == DIR_SOUTH);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign fin_cnt = r_cnt + RUN_W'(i_cmd.fin_plus);

    // walk state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_start_x  <= i_in_item.cell_x;
            r_start_y  <= i_in_item.cell_y;
            r_skip     <= i_in_item.skip_dir;
            r_dir      <= DIR_EAST;
            r_x        <= $signed(POS_W'(i_in_item.cell_x));
            r_y        <= $signed(POS_W'(i_in_item.cell_y));
            r_cnt      <= '0;
            r_best_run <= '0;
            r_best_dir <= DIR_EAST;
        end else if (i_cmd.step) begin
            r_x   <= nx;
            r_y   <= ny;
            r_cnt <= r_cnt + RUN_W'(1);
        end else if (i_cmd.finish) begin
            if (fin_cnt > r_best_run && r_dir != r_skip) begin
                r_best_run <= fin_cnt;
                r_best_dir <= r_dir;
            end
            r_dir <= r_dir + DIR_W'(1);
            r_x   <= $signed(POS_W'(r_start_x));
            r_y   <= $signed(POS_W'(r_start_y));
            r_cnt <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.best_dir <= r_best_dir;
            r_out_item.best_run <= r_best_run;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> o_out_valid)
        else $error("emit did not raise output valid");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("emit over a held item");

    a_step_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_cnt == $past(r_cnt) + RUN_W'(1)))
        else $error("step did not advance the run counter");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_best_run != '0))
        else $error("result with empty run");
`endif

endmodule

// File: rtl/core/free_run_direction_picker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_run_direction_picker_top
// picks the longest free ray (east, west, north, south) from a start cell
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  --------------------------------
//  in        input      i_in_valid/o_in_stall  i_in_item  (write or query)
//  out       output     o_out_valid/i_out_stall o_out_item (best_dir, best_run)
//  cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  a write item is stored in the map as it is taken; a query walks the four
//  rays in turn, one map read a cycle, each ray ending when it leaves the grid
//  or stops on a blocked or visited cell, and then its result is emitted
//  reset (synchronous, active low) clears the sequencer, the output register
//  and the limits (both 64); map contents are undefined until written
//  the input stalls while a query walks and until its result is in the output
//  register; the next item is taken while that result waits
//
module free_run_direction_picker_top #(
    parameter int MAX_COLS = fdp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = fdp_pkg::MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fdp_pkg::t_in_item             i_in_item,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fdp_pkg::t_out_item            o_out_item,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fdp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fdp_pkg::LIM_W-1:0]     i_cfg_data
);
    import fdp_pkg::*;

    t_fdp_cmd  cmd;
    t_fdp_stat stat;

    // config writes are registered and always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: idle / first step / walk / emit
    fdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // maps, limits, walk position, best ray and output register
    fdp_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

`ifndef NO_ASSERTIONS
    a_no_take_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.op == OP_QUERY) |=> o_in_stall)
        else $error("query did not hold off the input");

    a_cmd_only_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_cell || cmd.load_query) |-> (i_in_valid && !o_in_stall))
        else $error("item command without an accepted item");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_cell |=> !o_in_stall)
        else $error("write left the input stalled");
`endif

endmodule
